// File: src/bsspt_pkg.sv
// Shared types, constants and helper functions for the button-set single-pulse timer.
`default_nettype none
package bsspt_pkg;

    localparam int C_TW      = 16;
    localparam int C_DUR_W   = 8;
    localparam int C_MS_W    = 14;
    localparam int C_UNIT_W  = 7;
    localparam int C_PULSE_W = C_DUR_W + C_UNIT_W;
    localparam int C_IDX_W   = 3;
    localparam int C_DATA_W  = 14;

    localparam logic [C_TW-1:0] C_TMAX = '1;

    // Configuration register indexes.
    localparam logic [C_IDX_W-1:0] CFG_START_DURATION  = 3'd0;
    localparam logic [C_IDX_W-1:0] CFG_MIN_DURATION    = 3'd1;
    localparam logic [C_IDX_W-1:0] CFG_MAX_DURATION    = 3'd2;
    localparam logic [C_IDX_W-1:0] CFG_HOLD_DELAY      = 3'd3;
    localparam logic [C_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd4;
    localparam logic [C_IDX_W-1:0] CFG_REST_TIME       = 3'd5;
    localparam logic [C_IDX_W-1:0] CFG_UNIT_MS         = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [C_DUR_W-1:0]  RST_START_DURATION  = 8'd1;
    localparam logic [C_DUR_W-1:0]  RST_MIN_DURATION    = 8'd1;
    localparam logic [C_DUR_W-1:0]  RST_MAX_DURATION    = 8'd99;
    localparam logic [C_MS_W-1:0]   RST_HOLD_DELAY      = 14'd500;
    localparam logic [C_MS_W-1:0]   RST_REPEAT_INTERVAL = 14'd100;
    localparam logic [C_MS_W-1:0]   RST_REST_TIME       = 14'd500;
    localparam logic [C_UNIT_W-1:0] RST_UNIT_MS         = 7'd10;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HOLD   = 3'd1,
        MODE_REPEAT = 3'd2,
        MODE_FIRE   = 3'd3,
        MODE_REST   = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [C_DUR_W-1:0] duration;
        logic               step_up;
        logic [C_TW-1:0]    hold_t;
        logic [C_TW-1:0]    rep_t;
        logic [C_TW-1:0]    fire_t;
    } t_state;

    // Wait thresholds, already lowered below the timer maximum.
    typedef struct packed {
        logic [C_TW-1:0]    hold_lim;
        logic [C_TW-1:0]    rep_lim;
        logic [C_TW-1:0]    pulse_lim;
        logic [C_TW-1:0]    rest_lim;
        logic [C_DUR_W-1:0] min_dur;
        logic [C_DUR_W-1:0] max_dur;
    } t_limits;

    // Saturating one-millisecond timer increment.
    function automatic logic [C_TW-1:0] f_tick(input logic [C_TW-1:0] t);
        return (t < C_TMAX) ? t + 1'b1 : C_TMAX;
    endfunction

    // A threshold at or above the timer maximum becomes the maximum minus one.
    function automatic logic [C_TW-1:0] f_limit(input logic [C_TW:0] thr);
        logic [C_TW:0] tmax_ext;
        tmax_ext = {1'b0, C_TMAX};
        return (thr < tmax_ext) ? thr[C_TW-1:0] : C_TMAX - 1'b1;
    endfunction

    // One step of the duration, refused at the limit in that direction.
    function automatic logic [C_DUR_W-1:0] f_step(
        input logic [C_DUR_W-1:0] d,
        input logic               up,
        input logic [C_DUR_W-1:0] mn,
        input logic [C_DUR_W-1:0] mx
    );
        logic [C_DUR_W-1:0] r;
        r = d;
        if (up) begin
            if (d < mx) r = d + 1'b1;
        end else begin
            if (d > mn) r = d - 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/bsspt_if.sv
// Handshake channel interfaces: tick input, result output and configuration write.
`default_nettype none
interface bsspt_in_if;
    logic valid;
    logic ready;
    logic right_pressed;
    logic left_pressed;
    logic fire_pressed;
    logic right_released;
    logic left_released;
    modport source (output valid, right_pressed, left_pressed, fire_pressed,
                    right_released, left_released, input ready);
    modport sink   (input valid, right_pressed, left_pressed, fire_pressed,
                    right_released, left_released, output ready);
endinterface

interface bsspt_out_if;
    logic       valid;
    logic       ready;
    logic       pulse_level;
    logic [7:0] duration_value;
    logic [2:0] mode;
    logic       save_strobe;
    modport source (output valid, pulse_level, duration_value, mode, save_strobe,
                    input ready);
    modport sink   (input valid, pulse_level, duration_value, mode, save_strobe,
                    output ready);
endinterface

interface bsspt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [13:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/bsspt_step.sv
// Next-state logic for one millisecond tick of the timer.
`default_nettype none
module bsspt_step
    import bsspt_pkg::*;
(
    input  wire t_state  i_state,
    input  wire t_limits i_lim,
    input  wire logic    i_right_pressed,
    input  wire logic    i_left_pressed,
    input  wire logic    i_fire_pressed,
    input  wire logic    i_right_released,
    input  wire logic    i_left_released,
    output t_state       o_state,
    output logic         o_save
);

    logic released;

    assign released = i_right_released || i_left_released;

    always_comb begin
        o_state = i_state;
        o_save  = 1'b0;
        case (i_state.mode)
            MODE_HOLD: begin
                o_state.hold_t = f_tick(i_state.hold_t);
                o_state.rep_t  = f_tick(i_state.rep_t);
                // Expiry wins over a release on the same tick.
                if (o_state.hold_t > i_lim.hold_lim) begin
                    o_state.mode = MODE_REPEAT;
                end else if (released) begin
                    o_state.mode = MODE_IDLE;
                end
            end
            MODE_REPEAT: begin
                o_state.rep_t = f_tick(i_state.rep_t);
                if (released) begin
                    o_state.mode = MODE_IDLE;
                end else if (o_state.rep_t > i_lim.rep_lim) begin
                    o_state.rep_t    = '0;
                    o_state.duration = f_step(i_state.duration, i_state.step_up,
                                              i_lim.min_dur, i_lim.max_dur);
                end
            end
            MODE_FIRE: begin
                o_state.fire_t = f_tick(i_state.fire_t);
                if (o_state.fire_t > i_lim.pulse_lim) begin
                    o_state.mode = MODE_REST;
                end
            end
            MODE_REST: begin
                o_state.fire_t = f_tick(i_state.fire_t);
                if (o_state.fire_t > i_lim.rest_lim) begin
                    o_state.mode = MODE_IDLE;
                end
            end
            default: begin
                if (i_right_pressed || i_left_pressed) begin
                    o_state.mode     = MODE_HOLD;
                    o_state.hold_t   = '0;
                    o_state.rep_t    = '0;
                    o_state.step_up  = i_right_pressed;
                    o_state.duration = f_step(i_state.duration, i_right_pressed,
                                              i_lim.min_dur, i_lim.max_dur);
                end else if (i_fire_pressed) begin
                    o_state.mode   = MODE_FIRE;
                    o_state.fire_t = '0;
                    o_save         = 1'b1;
                end else begin
                    o_state.mode = MODE_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/button_set_single_pulse_timer.sv
// Top level of the button-set single-pulse timer.
// The result beat for a tick appears in the cycle after the tick beat is accepted.
// Throughput: one tick per cycle with o_out.ready high; mode, timers, duration step as one.
// The output register lets a new tick in while the current result is being taken.
// Reset (synchronous, active low) restores the configuration registers to their values,
// loads the duration from start_duration and puts the block in idle with timers cleared.
`default_nettype none
module button_set_single_pulse_timer
    import bsspt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bsspt_in_if.sink     i_in,
    bsspt_out_if.source  o_out,
    bsspt_cfg_if.sink    i_cfg
);

    // Configuration registers.
    logic [C_DUR_W-1:0]  r_min_dur;
    logic [C_DUR_W-1:0]  r_max_dur;
    logic [C_MS_W-1:0]   r_hold_delay;
    logic [C_MS_W-1:0]   r_rep_interval;
    logic [C_MS_W-1:0]   r_rest_time;
    logic [C_UNIT_W-1:0] r_unit;

    // Timer state.
    t_state              r_state;
    t_state              n_state;

    // Result register.
    logic                r_out_valid;
    logic                r_pulse;
    logic [C_DUR_W-1:0]  r_dur_out;
    logic [2:0]          r_mode_out;
    logic                r_save;

    t_limits              lim;
    logic [C_PULSE_W-1:0] pulse_len;
    logic [C_TW:0]        rest_sum;
    logic                 n_save;
    logic                 in_beat;
    logic                 cfg_beat;

    assign i_cfg.ready = 1'b1;
    assign cfg_beat    = i_cfg.valid && i_cfg.ready;

    // A tick is taken whenever the result register is empty or is being emptied.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_beat     = i_in.valid && i_in.ready;

    // The pulse length is the duration times the unit, and the rest ends that many
    // milliseconds plus the rest time after the fire press. Both follow the current
    // registers directly, so a write made while the pulse or the rest runs takes
    // effect on the very next tick.
    assign pulse_len = C_PULSE_W'(r_state.duration) * C_PULSE_W'(r_unit);
    assign rest_sum  = (C_TW + 1)'(pulse_len) + (C_TW + 1)'(r_rest_time);

    always_comb begin
        lim.hold_lim  = f_limit((C_TW + 1)'(r_hold_delay));
        lim.rep_lim   = f_limit((C_TW + 1)'(r_rep_interval));
        lim.pulse_lim = f_limit((C_TW + 1)'(pulse_len));
        lim.rest_lim  = f_limit(rest_sum);
        lim.min_dur   = r_min_dur;
        lim.max_dur   = r_max_dur;
    end

    bsspt_step u_step (
        .i_state          (r_state),
        .i_lim            (lim),
        .i_right_pressed  (i_in.right_pressed),
        .i_left_pressed   (i_in.left_pressed),
        .i_fire_pressed   (i_in.fire_pressed),
        .i_right_released (i_in.right_released),
        .i_left_released  (i_in.left_released),
        .o_state          (n_state),
        .o_save           (n_save)
    );

    // Configuration writes. A start_duration write goes straight into the duration
    // held in the timer state, so it needs no register of its own here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dur      <= RST_MIN_DURATION;
            r_max_dur      <= RST_MAX_DURATION;
            r_hold_delay   <= RST_HOLD_DELAY;
            r_rep_interval <= RST_REPEAT_INTERVAL;
            r_rest_time    <= RST_REST_TIME;
            r_unit         <= RST_UNIT_MS;
        end else if (cfg_beat) begin
            case (i_cfg.index)
                CFG_MIN_DURATION:    r_min_dur      <= i_cfg.data[C_DUR_W-1:0];
                CFG_MAX_DURATION:    r_max_dur      <= i_cfg.data[C_DUR_W-1:0];
                CFG_HOLD_DELAY:      r_hold_delay   <= i_cfg.data[C_MS_W-1:0];
                CFG_REPEAT_INTERVAL: r_rep_interval <= i_cfg.data[C_MS_W-1:0];
                CFG_REST_TIME:       r_rest_time    <= i_cfg.data[C_MS_W-1:0];
                CFG_UNIT_MS:         r_unit         <= i_cfg.data[C_UNIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Timer state. The user must write configuration only while no tick is in flight, so
    // a start duration write and a tick beat never meet; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= MODE_IDLE;
            r_state.duration <= RST_START_DURATION;
            r_state.step_up  <= 1'b1;
            r_state.hold_t   <= '0;
            r_state.rep_t    <= '0;
            r_state.fire_t   <= '0;
        end else if (cfg_beat && (i_cfg.index == CFG_START_DURATION)) begin
            r_state.duration <= i_cfg.data[C_DUR_W-1:0];
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // Result register: holds the state after the tick until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pulse    <= (n_state.mode == MODE_FIRE);
            r_dur_out  <= n_state.duration;
            r_mode_out <= n_state.mode;
            r_save     <= n_save;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pulse_level    = r_pulse;
    assign o_out.duration_value = r_dur_out;
    assign o_out.mode           = r_mode_out;
    assign o_out.save_strobe    = r_save;

endmodule
`default_nettype wire
